@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the quaternion triple product RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property while out of reset.
`define QTP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: lbl");

// Check a property at every edge, reset included.
`define QTP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed: lbl");

`else

`define QTP_ASSERT(lbl, clk, rst_n, prop)
`define QTP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ design/qtp_pkg.sv @@
// ----------------------------------------------------------------------------
// qtp_pkg
// Types and constants of the quaternion triple product block.
// ----------------------------------------------------------------------------
package qtp_pkg;

    // Default configuration
    localparam int QTP_FRAC_BITS   = 14;
    localparam int QTP_QUEUE_DEPTH = 4;

    // Datapath widths
    localparam int CompW = 16;          // one quaternion component
    localparam int SumW  = CompW + 1;   // sum or difference of two components
    localparam int ProdW = 2 * SumW;    // full product of two sums
    localparam int CombW = ProdW + 3;   // combination of up to five products

    typedef logic signed [CompW-1:0] t_comp;

    typedef struct packed {
        t_comp w;
        t_comp x;
        t_comp y;
        t_comp z;
    } t_quat;

    // Input request payload
    typedef struct packed {
        t_comp a_w;
        t_comp a_x;
        t_comp a_y;
        t_comp a_z;
        t_comp b_w;
        t_comp b_x;
        t_comp b_y;
        t_comp b_z;
        t_comp c_w;
        t_comp c_x;
        t_comp c_y;
        t_comp c_z;
    } t_in_item;

    // Result request payload
    typedef struct packed {
        t_comp res_w;
        t_comp res_x;
        t_comp res_y;
        t_comp res_z;
        logic  overflow;
    } t_out_item;

    // Entry of the queue between the first and second product
    typedef struct packed {
        t_quat m;
        t_quat c;
        logic  ovf;
    } t_mid;

endpackage

@@ design/qtp_intf.sv @@
// ----------------------------------------------------------------------------
// qtp_intf
// Valid/ready channels for input requests and result requests.
// ----------------------------------------------------------------------------
interface qtp_in_if;
    logic               valid;
    logic               ready;
    qtp_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qtp_out_if;
    logic               valid;
    logic               ready;
    qtp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/quaternion_triple_product.sv @@
// ----------------------------------------------------------------------------
// quaternion_triple_product
// Computes d = (a*b)*c on Q1.14 quaternions with saturation and overflow flag.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless stalled; each product pipeline
// is four stages. The front product drains into a queue of QUEUE_DEPTH
// entries, so either side may stall on its own. Synchronous active-low
// reset empties the pipelines and the queue; no other state is kept.
module quaternion_triple_product #(
    parameter int FRAC_BITS   = qtp_pkg::QTP_FRAC_BITS,
    parameter int QUEUE_DEPTH = qtp_pkg::QTP_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qtp_in_if.sink    i_in,
    qtp_out_if.source o_out
);

    qtp_pkg::t_quat a;
    qtp_pkg::t_quat b;
    qtp_pkg::t_quat c;

    logic           f_vld;
    qtp_pkg::t_quat f_m;
    logic           f_ovf;
    qtp_pkg::t_quat f_c;
    qtp_pkg::t_mid  f_entry;

    logic           q_ready;
    logic           q_vld;
    qtp_pkg::t_mid  q_data;

    logic           b_ready;
    qtp_pkg::t_quat b_r;
    logic           b_ovf;

    // Split the request into its quaternions
    assign a = '{w: i_in.data.a_w, x: i_in.data.a_x, y: i_in.data.a_y, z: i_in.data.a_z};
    assign b = '{w: i_in.data.b_w, x: i_in.data.b_x, y: i_in.data.b_y, z: i_in.data.b_z};
    assign c = '{w: i_in.data.c_w, x: i_in.data.c_x, y: i_in.data.c_y, z: i_in.data.c_z};

    // Front: a*b, carrying c alongside
    qtp_hamilton #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in.valid),
        .i_p     (a),
        .i_q     (b),
        .i_ovf   (1'b0),
        .i_side  (c),
        .o_ready (i_in.ready),
        .o_vld   (f_vld),
        .o_r     (f_m),
        .o_ovf   (f_ovf),
        .o_side  (f_c),
        .i_ready (q_ready)
    );

    assign f_entry = '{m: f_m, c: f_c, ovf: f_ovf};

    // Queue between front and back
    qtp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_data  (f_entry),
        .o_ready (q_ready),
        .o_vld   (q_vld),
        .o_data  (q_data),
        .i_pop   (b_ready)
    );

    // Back: (a*b)*c
    qtp_hamilton #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_p     (q_data.m),
        .i_q     (q_data.c),
        .i_ovf   (q_data.ovf),
        .i_side  ('0),
        .o_ready (b_ready),
        .o_vld   (o_out.valid),
        .o_r     (b_r),
        .o_ovf   (b_ovf),
        .o_side  (),
        .i_ready (o_out.ready)
    );

    assign o_out.data = '{res_w: b_r.w, res_x: b_r.x, res_y: b_r.y, res_z: b_r.z,
                          overflow: b_ovf};

endmodule

@@ design/qtp_hamilton.sv @@
// ----------------------------------------------------------------------------
// qtp_hamilton
// Four-stage pipelined eight-multiply Hamilton product r = p*q with saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qtp_hamilton #(
    parameter int FRAC_BITS = qtp_pkg::QTP_FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  qtp_pkg::t_quat i_p,
    input  qtp_pkg::t_quat i_q,
    input  logic           i_ovf,
    input  qtp_pkg::t_quat i_side,
    output logic           o_ready,
    output logic           o_vld,
    output qtp_pkg::t_quat o_r,
    output logic           o_ovf,
    output qtp_pkg::t_quat o_side,
    input  logic           i_ready
);

    localparam int SumW  = qtp_pkg::SumW;
    localparam int ProdW = qtp_pkg::ProdW;
    localparam int CombW = qtp_pkg::CombW;
    localparam int CompW = qtp_pkg::CompW;
    localparam int NumStg = 4;

    localparam logic signed [CombW-1:0] SatMax = CombW'(32767);
    localparam logic signed [CombW-1:0] SatMin = -CombW'(32768);

    // Product indexes
    localparam int IdxA = 0;
    localparam int IdxB = 1;
    localparam int IdxC = 2;
    localparam int IdxD = 3;
    localparam int IdxE = 4;
    localparam int IdxF = 5;
    localparam int IdxG = 6;
    localparam int IdxH = 7;

    logic                    en;
    logic [NumStg-1:0]       r_vld;
    logic [NumStg-2:0]       r_ovf_d;
    qtp_pkg::t_quat          r_side [NumStg];

    logic signed [SumW-1:0]  n_sp [8];
    logic signed [SumW-1:0]  n_sq [8];
    logic signed [SumW-1:0]  r_sp [8];
    logic signed [SumW-1:0]  r_sq [8];
    logic signed [ProdW-1:0] r_pr [8];
    logic signed [CombW-1:0] sh [8];
    logic signed [CombW-1:0] n_cmb [4];
    logic signed [CombW-1:0] r_cmb [4];
    logic signed [CompW-1:0] n_res [4];
    logic [3:0]              n_sat;
    qtp_pkg::t_quat          r_r;
    logic                    r_ovf;

    // Advance the whole pipe unless the last stage holds a result nobody takes
    assign en      = !r_vld[NumStg-1] || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NumStg-2:0], i_vld};
        end
    end

    // Pairwise sums and differences
    always_comb begin
        n_sp[IdxA] = SumW'(i_p.w) + SumW'(i_p.x);
        n_sq[IdxA] = SumW'(i_q.w) + SumW'(i_q.x);
        n_sp[IdxB] = SumW'(i_p.z) - SumW'(i_p.y);
        n_sq[IdxB] = SumW'(i_q.y) - SumW'(i_q.z);
        n_sp[IdxC] = SumW'(i_p.w) - SumW'(i_p.x);
        n_sq[IdxC] = SumW'(i_q.y) + SumW'(i_q.z);
        n_sp[IdxD] = SumW'(i_p.y) + SumW'(i_p.z);
        n_sq[IdxD] = SumW'(i_q.w) - SumW'(i_q.x);
        n_sp[IdxE] = SumW'(i_p.x) + SumW'(i_p.z);
        n_sq[IdxE] = SumW'(i_q.x) + SumW'(i_q.y);
        n_sp[IdxF] = SumW'(i_p.x) - SumW'(i_p.z);
        n_sq[IdxF] = SumW'(i_q.x) - SumW'(i_q.y);
        n_sp[IdxG] = SumW'(i_p.w) + SumW'(i_p.y);
        n_sq[IdxG] = SumW'(i_q.w) - SumW'(i_q.z);
        n_sp[IdxH] = SumW'(i_p.w) - SumW'(i_p.y);
        n_sq[IdxH] = SumW'(i_q.w) + SumW'(i_q.z);
    end

    // Stage 1 and 2: sums, then the eight products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 8; k++) begin
                r_sp[k] <= n_sp[k];
                r_sq[k] <= n_sq[k];
                r_pr[k] <= r_sp[k] * r_sq[k];
            end
        end
    end

    // Drop the fraction bits, then combine
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            sh[k] = CombW'(r_pr[k] >>> FRAC_BITS);
        end
        n_cmb[0] = sh[IdxB] + ((-sh[IdxE] - sh[IdxF] + sh[IdxG] + sh[IdxH]) >>> 1);
        n_cmb[1] = sh[IdxA] - (( sh[IdxE] + sh[IdxF] + sh[IdxG] + sh[IdxH]) >>> 1);
        n_cmb[2] = sh[IdxC] + (( sh[IdxE] - sh[IdxF] + sh[IdxG] - sh[IdxH]) >>> 1);
        n_cmb[3] = sh[IdxD] + (( sh[IdxE] - sh[IdxF] - sh[IdxG] + sh[IdxH]) >>> 1);
    end

    // Clamp each component to 16 bits
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_cmb[k] > SatMax) begin
                n_res[k] = CompW'(32767);
                n_sat[k] = 1'b1;
            end else if (r_cmb[k] < SatMin) begin
                n_res[k] = -CompW'(32768);
                n_sat[k] = 1'b1;
            end else begin
                n_res[k] = r_cmb[k][CompW-1:0];
                n_sat[k] = 1'b0;
            end
        end
    end

    // Stage 3 and 4: combination, then saturated result
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_cmb[k] <= n_cmb[k];
            end
            r_r.w <= n_res[0];
            r_r.x <= n_res[1];
            r_r.y <= n_res[2];
            r_r.z <= n_res[3];
            r_ovf_d <= {r_ovf_d[NumStg-3:0], i_ovf};
            r_ovf   <= r_ovf_d[NumStg-2] | (|n_sat);
            r_side[0] <= i_side;
            for (int k = 1; k < NumStg; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[NumStg-1];
    assign o_r    = r_r;
    assign o_ovf  = r_ovf;
    assign o_side = r_side[NumStg-1];

    `QTP_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !o_vld)
    `QTP_ASSERT(a_stall_holds, i_clk, i_rst_n, (o_vld && !i_ready) |=> (o_vld && $stable(o_r) && $stable(o_ovf)))

endmodule

@@ design/qtp_fifo.sv @@
// ----------------------------------------------------------------------------
// qtp_fifo
// Small queue between the first and second product pipelines.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qtp_fifo #(
    parameter int DEPTH = qtp_pkg::QTP_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qtp_pkg::t_mid i_data,
    output logic          o_ready,
    output logic          o_vld,
    output qtp_pkg::t_mid o_data,
    input  logic          i_pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    qtp_pkg::t_mid   r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;
    logic            push;
    logic            pop;

    assign o_ready = (r_count != CntW'(DEPTH));
    assign o_vld   = (r_count != '0);
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_vld;

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `QTP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CntW'(DEPTH))
    `QTP_ASSERT(a_push_counts, i_clk, i_rst_n, (push && !pop) |=> (r_count == $past(r_count) + 1'b1))

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the quaternion triple product block, d = (a*b)*c with saturation.
// Requests go in over the input channel and every result is compared,
// field by field, against a bit-exact software model of the two Hamilton
// products. Directed requests cover identities, extremes and saturation.
// Random traffic follows, with bursts of idling on both channels, and
// then a closing stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     Frac          = qtp_pkg::QTP_FRAC_BITS;
    localparam longint CompMax       = (64'sd1 <<< (qtp_pkg::CompW - 1)) - 1;
    localparam longint CompMin       = -(64'sd1 <<< (qtp_pkg::CompW - 1));
    localparam int     RandomCount   = 390;
    localparam int     FullRateCount = 45;
    localparam int     DrainCycles   = 16;
    localparam int     WatchdogLimit = 1000;

    logic i_clk;
    logic i_rst_n;

    qtp_in_if  in_if ();
    qtp_out_if out_if ();

    qtp_pkg::t_out_item expected_products[$];
    int                 mismatch_count = 0;
    int                 quiet_cycles   = 0;
    bit                 idle_on        = 1'b1;

    quaternion_triple_product dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Free-running clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Model of the datapath
    // ------------------------------------------------------------------------
    function automatic qtp_pkg::t_quat quat(input int w, input int x,
                                            input int y, input int z);
        qtp_pkg::t_quat q;
        q.w = qtp_pkg::t_comp'(w);
        q.x = qtp_pkg::t_comp'(x);
        q.y = qtp_pkg::t_comp'(y);
        q.z = qtp_pkg::t_comp'(z);
        return q;
    endfunction

    function automatic qtp_pkg::t_in_item triple(input qtp_pkg::t_quat a,
                                                 input qtp_pkg::t_quat b,
                                                 input qtp_pkg::t_quat c);
        qtp_pkg::t_in_item it;
        it.a_w = a.w; it.a_x = a.x; it.a_y = a.y; it.a_z = a.z;
        it.b_w = b.w; it.b_x = b.x; it.b_y = b.y; it.b_z = b.z;
        it.c_w = c.w; it.c_x = c.x; it.c_y = c.y; it.c_z = c.z;
        return it;
    endfunction

    function automatic qtp_pkg::t_comp clamp_comp(input longint v);
        if (v > CompMax) return qtp_pkg::t_comp'(CompMax);
        if (v < CompMin) return qtp_pkg::t_comp'(CompMin);
        return qtp_pkg::t_comp'(v);
    endfunction

    // Eight-multiply Hamilton product r = p*q, saturated to component width
    function automatic qtp_pkg::t_quat quat_mul(input qtp_pkg::t_quat p,
                                                input qtp_pkg::t_quat q,
                                                output logic sat);
        longint         pw, px, py, pz, qw, qx, qy, qz;
        longint         ta, tb, tc, td, te, tf, tg, th;
        longint         comb[4];
        qtp_pkg::t_quat r;
        pw = longint'(p.w); px = longint'(p.x); py = longint'(p.y); pz = longint'(p.z);
        qw = longint'(q.w); qx = longint'(q.x); qy = longint'(q.y); qz = longint'(q.z);
        // Products are floored by the fraction shift
        ta = ((pw + px) * (qw + qx)) >>> Frac;
        tb = ((pz - py) * (qy - qz)) >>> Frac;
        tc = ((pw - px) * (qy + qz)) >>> Frac;
        td = ((py + pz) * (qw - qx)) >>> Frac;
        te = ((px + pz) * (qx + qy)) >>> Frac;
        tf = ((px - pz) * (qx - qy)) >>> Frac;
        tg = ((pw + py) * (qw - qz)) >>> Frac;
        th = ((pw - py) * (qw + qz)) >>> Frac;
        comb[0] = tb + ((-te - tf + tg + th) >>> 1);
        comb[1] = ta - (( te + tf + tg + th) >>> 1);
        comb[2] = tc + (( te - tf + tg - th) >>> 1);
        comb[3] = td + (( te - tf - tg + th) >>> 1);
        sat = 1'b0;
        foreach (comb[k]) begin
            if (comb[k] > CompMax || comb[k] < CompMin) sat = 1'b1;
        end
        r.w = clamp_comp(comb[0]);
        r.x = clamp_comp(comb[1]);
        r.y = clamp_comp(comb[2]);
        r.z = clamp_comp(comb[3]);
        return r;
    endfunction

    function automatic qtp_pkg::t_out_item predict_triple(input qtp_pkg::t_in_item it);
        qtp_pkg::t_quat     a, b, c, m, d;
        logic               sat_mid, sat_end;
        qtp_pkg::t_out_item r;
        a = '{w: it.a_w, x: it.a_x, y: it.a_y, z: it.a_z};
        b = '{w: it.b_w, x: it.b_x, y: it.b_y, z: it.b_z};
        c = '{w: it.c_w, x: it.c_x, y: it.c_y, z: it.c_z};
        m = quat_mul(a, b, sat_mid);
        d = quat_mul(m, c, sat_end);
        r.res_w    = d.w;
        r.res_x    = d.x;
        r.res_y    = d.y;
        r.res_z    = d.z;
        r.overflow = sat_mid | sat_end;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    // Drive one request, with an optional idle burst first; valid stays high
    // after acceptance so back-to-back requests never toggle it.
    task automatic send_request(input qtp_pkg::t_in_item it);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 19);
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        expected_products.push_back(predict_triple(it));
    endtask

    // Mix full-range values, moderate values in [-1.0, 1.0] and corners
    function automatic qtp_pkg::t_comp rand_comp();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return qtp_pkg::t_comp'($urandom());
        if (pick < 8) return qtp_pkg::t_comp'(int'($urandom_range(0, 32768)) - 16384);
        case ($urandom_range(0, 7))
            0:       return qtp_pkg::t_comp'(CompMin);
            1:       return qtp_pkg::t_comp'(CompMax);
            2:       return qtp_pkg::t_comp'(-1);
            3:       return qtp_pkg::t_comp'(1);
            4:       return qtp_pkg::t_comp'(16384);
            5:       return qtp_pkg::t_comp'(-16384);
            6:       return qtp_pkg::t_comp'(CompMin + 1);
            default: return '0;
        endcase
    endfunction

    function automatic qtp_pkg::t_quat rand_quat();
        return quat(int'(rand_comp()), int'(rand_comp()), int'(rand_comp()),
                    int'(rand_comp()));
    endfunction

    // ------------------------------------------------------------------------
    // Result sink: ready with random stall bursts
    // ------------------------------------------------------------------------
    initial begin : ready_driver
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!idle_on) stall_left = 0;
            else if (stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 19);
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        qtp_pkg::t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_products.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: unexpected result, expected none, actual w=%0d x=%0d y=%0d z=%0d ovf=%0d",
                         $time, out_if.data.res_w, out_if.data.res_x,
                         out_if.data.res_y, out_if.data.res_z, out_if.data.overflow);
            end else begin
                want = expected_products.pop_front();
                check_field("res_w", int'(want.res_w), int'(out_if.data.res_w));
                check_field("res_x", int'(want.res_x), int'(out_if.data.res_x));
                check_field("res_y", int'(want.res_y), int'(out_if.data.res_y));
                check_field("res_z", int'(want.res_z), int'(out_if.data.res_z));
                check_field("overflow", int'(want.overflow), int'(out_if.data.overflow));
            end
        end
    end

    // Stop a hung run: count cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("%0t ns: no request moved for %0d cycles", $time, quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Unit quaternions: identity and i*i = j*j = k*k = -1
    task automatic test_identity();
        qtp_pkg::t_quat one, qi, qj, qk;
        one = quat(16384, 0, 0, 0);
        qi  = quat(0, 16384, 0, 0);
        qj  = quat(0, 0, 16384, 0);
        qk  = quat(0, 0, 0, 16384);
        send_request(triple(one, one, one));
        send_request(triple(qi, qi, one));
        send_request(triple(qj, qj, one));
        send_request(triple(qk, qk, one));
        send_request(triple(qi, qj, qk));
        send_request(triple(quat(8192, -8192, 8192, -8192), one, qk));
    endtask

    // Extremes of the component range
    task automatic test_extremes();
        qtp_pkg::t_quat zero, qmax, qmin, qalt;
        zero = quat(0, 0, 0, 0);
        qmax = quat(int'(CompMax), int'(CompMax), int'(CompMax), int'(CompMax));
        qmin = quat(int'(CompMin), int'(CompMin), int'(CompMin), int'(CompMin));
        qalt = quat(int'(CompMax), int'(CompMin), int'(CompMax), int'(CompMin));
        send_request(triple(zero, zero, zero));
        send_request(triple(qmax, qmax, qmax));
        send_request(triple(qmin, qmin, qmin));
        send_request(triple(qmin, qmax, qmin));
        send_request(triple(qalt, qmin, qmax));
        send_request(triple(qmax, qalt, qalt));
    endtask

    // Saturation in the first product only, in both, and floor rounding
    task automatic test_saturation();
        qtp_pkg::t_quat zero, one, negw;
        zero = quat(0, 0, 0, 0);
        one  = quat(16384, 0, 0, 0);
        negw = quat(int'(CompMin), 0, 0, 0);
        // Intermediate clips, final result is zero yet the flag stays set
        send_request(triple(negw, negw, zero));
        send_request(triple(negw, negw, negw));
        send_request(triple(negw, negw, one));
        // Small negative products round toward minus infinity
        send_request(triple(quat(-1, 0, 0, 0), quat(1, 0, 0, 0), one));
        send_request(triple(quat(1, 1, 1, 1), quat(-1, 1, -1, 1), one));
        send_request(triple(quat(-3, 5, -7, 9), quat(16383, -16383, 1, -1),
                            quat(-16384, 1, -1, 16384)));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_request(triple(rand_quat(), rand_quat(), rand_quat()));
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate(input int count);
        idle_on = 1'b0;
        test_random_traffic(count);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_identity();
        test_extremes();
        test_saturation();
        test_random_traffic(RandomCount);
        test_full_rate(FullRateCount);

        @(negedge i_clk);
        in_if.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (expected_products.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
